FILE: hdl/cfb_pkg.sv
// Package for the command frame builder: operation codes, sequencer states,
// register indexes, frame geometry and the CRC-8 byte update.
// No dependencies.
package cfb_pkg;

  localparam int MAX_PAYLOAD = 16;

  // Frame overhead: sync, code, length and CRC bytes.
  localparam int FRAME_OVERHEAD = 4;
  localparam int FRAME_W = $clog2(MAX_PAYLOAD + FRAME_OVERHEAD + 1);
  localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
  localparam int PIDX_W = $clog2(MAX_PAYLOAD);

  localparam int MOTOR_LEN = 16;
  localparam int SUBSCRIBE_LEN = 2;
  localparam int UNSUBSCRIBE_LEN = 0;

  localparam logic [7:0] CRC_POLY = 8'h07;
  localparam logic [7:0] SYNC_RESET = 8'hAA;
  localparam logic [7:0] CODE_MOTOR_RESET = 8'h31;
  localparam logic [7:0] CODE_SUBSCRIBE_RESET = 8'h40;
  localparam logic [7:0] CODE_UNSUBSCRIBE_RESET = 8'h41;

  // Fixed byte positions at the head of every frame.
  localparam logic [FRAME_W-1:0] POS_SYNC = FRAME_W'(0);
  localparam logic [FRAME_W-1:0] POS_CODE = FRAME_W'(1);
  localparam logic [FRAME_W-1:0] POS_LEN = FRAME_W'(2);
  localparam logic [FRAME_W-1:0] POS_PAYLOAD = FRAME_W'(3);

  typedef enum logic [1:0] {
    OP_MOTOR       = 2'd0,
    OP_STOP        = 2'd1,
    OP_SUBSCRIBE   = 2'd2,
    OP_UNSUBSCRIBE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_SYNC             = 2'd0,
    REG_CODE_MOTOR       = 2'd1,
    REG_CODE_SUBSCRIBE   = 2'd2,
    REG_CODE_UNSUBSCRIBE = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REFUSE,
    ST_EMIT
  } state_t;

  // CRC-8, MSB first, one byte per call.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: hdl/command_frame_builder_crc8_top.sv
// Command frame builder: turns one command request into a byte frame
// (sync, code, length, payload, CRC-8), or one no_room byte. Depends on cfb_pkg.
// The first frame byte is loaded into the output register from the emit state.
// A request occupies the sequencer until its whole frame, or the refusal byte, is
//   sent; the single CRC update unit and output register handle one byte per cycle
//   while byte_stall does not hold the output.
// Reset: rst is synchronous, active high; clears the sequencer, output valid and
//   CRC state, and loads the configuration registers with their defaults.
module command_frame_builder_crc8_top (
  input  logic                clk,
  input  logic                rst,
  // request channel
  input  logic                req_valid,
  output logic                req_stall,
  input  cfb_pkg::op_t        operation,
  input  logic signed [31:0]  setpoint_a,
  input  logic signed [31:0]  setpoint_b,
  input  logic signed [31:0]  setpoint_c,
  input  logic signed [31:0]  setpoint_d,
  input  logic [15:0]         report_interval,
  input  logic [15:0]         room,
  // frame byte channel
  output logic                byte_valid,
  input  logic                byte_stall,
  output logic [7:0]          frame_byte,
  output logic                last_byte,
  output logic                no_room,
  // configuration write port
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data
);
  import cfb_pkg::*;

  // Configuration registers.
  logic [7:0] sync_byte;
  logic [7:0] code_motor;
  logic [7:0] code_subscribe;
  logic [7:0] code_unsubscribe;

  // Sequencer and frame state.
  state_t             state;
  state_t             state_next;
  logic [FRAME_W-1:0] byte_position;
  logic [FRAME_W-1:0] frame_length;
  logic [LEN_W-1:0]   payload_len;
  logic [7:0]         crc_accumulator;
  logic [7:0]         held_code;
  logic [7:0]         payload_store [MAX_PAYLOAD];

  // Decode of the incoming request.
  logic               req_take;
  logic [LEN_W-1:0]   req_len;
  logic [FRAME_W-1:0] req_total;
  logic [7:0]         req_code;
  logic               req_refuse;
  logic [127:0]       motor_bytes;

  // Byte emission.
  logic               out_free;
  logic               emit_fire;
  logic               refuse_fire;
  logic               at_last;
  logic [FRAME_W-1:0] payload_offset;
  logic [7:0]         emit_byte;
  logic               crc_covers;

  // ---------------------------------------------------------------------
  // Configuration writes: taken any time; the user must issue them only while idle.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte        <= SYNC_RESET;
      code_motor       <= CODE_MOTOR_RESET;
      code_subscribe   <= CODE_SUBSCRIBE_RESET;
      code_unsubscribe <= CODE_UNSUBSCRIBE_RESET;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_SYNC:             sync_byte        <= cfg_data;
        REG_CODE_MOTOR:       code_motor       <= cfg_data;
        REG_CODE_SUBSCRIBE:   code_subscribe   <= cfg_data;
        REG_CODE_UNSUBSCRIBE: code_unsubscribe <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Request decode: payload length, code and room check.
  // ---------------------------------------------------------------------
  always_comb begin
    case (operation)
      OP_MOTOR, OP_STOP: begin
        req_len  = LEN_W'(MOTOR_LEN);
        req_code = code_motor;
      end
      OP_SUBSCRIBE: begin
        req_len  = LEN_W'(SUBSCRIBE_LEN);
        req_code = code_subscribe;
      end
      default: begin
        req_len  = LEN_W'(UNSUBSCRIBE_LEN);
        req_code = code_unsubscribe;
      end
    endcase
  end

  assign req_total   = FRAME_W'(req_len) + FRAME_W'(FRAME_OVERHEAD);
  assign req_refuse  = (room < 16'(req_total));
  // Little-endian setpoints, setpoint_a first; stop sends all zeros.
  assign motor_bytes = (operation == OP_MOTOR) ?
                       {setpoint_d, setpoint_c, setpoint_b, setpoint_a} : '0;

  // ---------------------------------------------------------------------
  // Sequencer: next state.
  // ---------------------------------------------------------------------
  assign out_free = !byte_valid || !byte_stall;
  assign at_last  = (byte_position == frame_length - FRAME_W'(1));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = req_refuse ? ST_REFUSE : ST_EMIT;
        end
      end
      ST_REFUSE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free && at_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer: control outputs.
  // ---------------------------------------------------------------------
  always_comb begin
    req_stall   = 1'b1;
    emit_fire   = 1'b0;
    refuse_fire = 1'b0;
    case (state)
      ST_IDLE:   req_stall   = 1'b0;
      ST_REFUSE: refuse_fire = out_free;
      ST_EMIT:   emit_fire   = out_free;
      default:   req_stall   = 1'b1;
    endcase
  end

  assign req_take = req_valid && !req_stall;

  // Select the byte for the current position; sync and CRC bytes are not covered.
  assign payload_offset = byte_position - POS_PAYLOAD;

  always_comb begin
    crc_covers = 1'b0;
    if (byte_position == POS_SYNC) begin
      emit_byte = sync_byte;
    end else if (at_last) begin
      emit_byte = crc_accumulator;
    end else if (byte_position == POS_CODE) begin
      emit_byte  = held_code;
      crc_covers = 1'b1;
    end else if (byte_position == POS_LEN) begin
      emit_byte  = 8'(payload_len);
      crc_covers = 1'b1;
    end else begin
      emit_byte  = payload_store[payload_offset[PIDX_W-1:0]];
      crc_covers = 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // Control registers.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      byte_position   <= '0;
      crc_accumulator <= '0;
      frame_length    <= '0;
      held_code       <= '0;
      payload_len     <= '0;
      byte_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (req_take) begin
        // Start a fresh frame: hold code and length, clear position and CRC.
        byte_position   <= '0;
        crc_accumulator <= '0;
        held_code       <= req_code;
        payload_len     <= req_len;
        if (!req_refuse) begin
          frame_length <= req_total;
        end
      end else if (emit_fire) begin
        byte_position <= at_last ? '0 : byte_position + FRAME_W'(1);
        if (crc_covers) begin
          crc_accumulator <= crc8_update(crc_accumulator, emit_byte);
        end
      end

      // Output register: load on a fire, drop once taken downstream.
      if (emit_fire || refuse_fire) begin
        byte_valid <= 1'b1;
      end else if (!byte_stall) begin
        byte_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output payload register.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (refuse_fire) begin
      frame_byte <= 8'h00;
      last_byte  <= 1'b1;
      no_room    <= 1'b1;
    end else if (emit_fire) begin
      frame_byte <= emit_byte;
      last_byte  <= at_last;
      no_room    <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // Payload store: loaded all at once when a motor, stop or subscribe request is taken.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (req_take) begin
      for (int i = 0; i < MAX_PAYLOAD; i++) begin
        if ((operation == OP_MOTOR || operation == OP_STOP) && i < MOTOR_LEN) begin
          payload_store[i] <= motor_bytes[8*i +: 8];
        end else if (operation == OP_SUBSCRIBE && i < SUBSCRIBE_LEN) begin
          payload_store[i] <= report_interval[8*(i % SUBSCRIBE_LEN) +: 8];
        end
      end
    end
  end

endmodule
